// ===== src/infix_to_postfix_converter_macros.svh =====
// Assertion macros shared by the infix-to-postfix converter RTL.
// Included by modules that check their own logic; needs clk and rst_n in scope.
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`ifndef SYNTHESIS
`define I2P_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2p assertion failed");
`define I2P_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2p assertion failed");
`else
`define I2P_ASSERT(lbl, ante, cons)
`define I2P_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/i2p_pkg.sv =====
// Shared types, codes and character helpers for the infix-to-postfix converter.
// No dependencies; used by i2p_ctrl, i2p_datapath and the top level.
`default_nettype none

package i2p_pkg;

    // ASCII characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;

    // Character classes
    localparam logic [2:0] CLS_ALNUM = 3'd0;
    localparam logic [2:0] CLS_SPACE = 3'd1;
    localparam logic [2:0] CLS_OPEN  = 3'd2;
    localparam logic [2:0] CLS_CLOSE = 3'd3;
    localparam logic [2:0] CLS_OPER  = 3'd4;
    localparam logic [2:0] CLS_BAD   = 3'd5;

    // Stack entry codes
    localparam logic [2:0] OP_PAREN = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_SUB   = 3'd2;
    localparam logic [2:0] OP_MUL   = 3'd3;
    localparam logic [2:0] OP_DIV   = 3'd4;
    localparam logic [2:0] OP_POW   = 3'd5;

    // Class of the previous token
    localparam logic [1:0] PREV_START = 2'd0;
    localparam logic [1:0] PREV_OPND  = 2'd1;
    localparam logic [1:0] PREV_CLOSE = 2'd2;
    localparam logic [1:0] PREV_OPER  = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_PAREN    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;
    localparam logic [1:0] ERR_BAD_CHAR = 2'd3;

    // Source of an emitted byte
    localparam logic [1:0] SRC_CHAR  = 2'd0;
    localparam logic [1:0] SRC_SPACE = 2'd1;
    localparam logic [1:0] SRC_TOP   = 2'd2;
    localparam logic [1:0] SRC_ZERO  = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] err;
    } res_t;

    typedef struct packed {
        logic       latch_in;
        logic       emit;
        logic [1:0] emit_src;
        logic       emit_last;
        logic [1:0] emit_err;
        logic       flush;
        logic       push;
        logic       push_paren;
        logic       pop;
        logic       set_inside;
        logic       clr_inside;
        logic       set_prev;
        logic [1:0] prev_val;
        logic       clear_expr;
        logic       set_discard;
        logic       clr_discard;
    } i2p_cmd_t;

    typedef struct packed {
        logic       emit_ok;
        logic       out_free;
        logic [2:0] cls;
        logic [2:0] op;
        logic       last;
        logic       discarding;
        logic       tok_open;
        logic [1:0] prev;
        logic       cnt_zero;
        logic       full;
        logic       top_paren;
        logic       top_ge;
    } i2p_stat_t;

    function automatic logic [2:0] char_class(input logic [7:0] c);
        logic [2:0] cls;
        if (c inside {[CH_0:CH_9], [CH_UA:CH_UZ], [CH_LA:CH_LZ]})
            cls = CLS_ALNUM;
        else if (c == CH_SPACE || c inside {[CH_TAB:CH_CR]})
            cls = CLS_SPACE;
        else if (c == CH_LPAREN)
            cls = CLS_OPEN;
        else if (c == CH_RPAREN)
            cls = CLS_CLOSE;
        else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET})
            cls = CLS_OPER;
        else
            cls = CLS_BAD;
        return cls;
    endfunction

    function automatic logic [2:0] op_code(input logic [7:0] c);
        logic [2:0] code;
        case (c)
            CH_PLUS:  code = OP_ADD;
            CH_MINUS: code = OP_SUB;
            CH_STAR:  code = OP_MUL;
            CH_SLASH: code = OP_DIV;
            CH_CARET: code = OP_POW;
            default:  code = OP_PAREN;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] op_char(input logic [2:0] code);
        logic [7:0] c;
        case (code)
            OP_PAREN: c = CH_LPAREN;
            OP_ADD:   c = CH_PLUS;
            OP_SUB:   c = CH_MINUS;
            OP_MUL:   c = CH_STAR;
            OP_DIV:   c = CH_SLASH;
            OP_POW:   c = CH_CARET;
            default:  c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] op_prec(input logic [2:0] code);
        logic [1:0] p;
        case (code)
            OP_ADD, OP_SUB: p = 2'd1;
            OP_MUL, OP_DIV: p = 2'd2;
            OP_POW:         p = 2'd3;
            default:        p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== src/infix_to_postfix_converter.sv =====
// Top level of the infix-to-postfix converter (shunting yard, bounded stack).
// Depends on i2p_pkg, i2p_ctrl and i2p_datapath.
//
//   Channel  Signals                               Dir  Moves
//   input    in_valid/in_ready, in_byte, in_last   in   one infix character
//   output   out_valid/out_ready, out_byte,        out  one postfix character
//            out_last, out_error                        or an error marker
//
// Steps: a letter, digit, whitespace or dropped item is accepted, then decoded. An
// operator or parenthesis is accepted, decoded and handled, with a pop and a space
// step per operator popped; an error adds an error step. The final item then closes
// the token, pops each operator with its space, finds the stack empty, flushes the hold.
// A stall on out_ready holds the sequencer in place; no item is taken until the
// current one is done. Reset clears the stack count and flags, not stack entries.
`default_nettype none

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 16
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire  [7:0] in_byte,
    input  wire        in_last,
    output logic       out_valid,
    input  wire        out_ready,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic [1:0] out_error
);
    import i2p_pkg::*;

    // Commands down to the datapath, status back up to the sequencer
    i2p_cmd_t  cmd;
    i2p_stat_t stat;

    i2p_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Stack, token flags and the result registers
    i2p_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_error (out_error)
    );

endmodule

`default_nettype wire

// ===== src/i2p_datapath.sv =====
// Datapath of the infix-to-postfix converter: input latch, operator stack,
// token flags, one-deep hold stage and output register. Uses i2p_pkg and the macro header.
`default_nettype none
`include "infix_to_postfix_converter_macros.svh"

module i2p_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire  [7:0]           in_byte,
    input  wire                  in_last,
    input  i2p_pkg::i2p_cmd_t    cmd,
    output i2p_pkg::i2p_stat_t   stat,
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic [7:0]           out_byte,
    output logic                 out_last,
    output logic [1:0]           out_error
);
    import i2p_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    logic [7:0]       byte_reg;
    logic             last_reg;
    logic [2:0]       op_stack_reg [STACK_DEPTH];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             inside_reg, inside_next;
    logic [1:0]       prev_reg, prev_next;
    logic             discard_reg, discard_next;
    res_t             hold_reg, hold_next;
    logic             hold_valid_reg, hold_valid_next;
    res_t             out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic [IDX_W-1:0] top_idx;
    logic [2:0]       top_code;
    logic [2:0]       cur_op;
    logic             out_free;
    res_t             new_res;

    assign top_idx  = IDX_W'(cnt_reg - CNT_W'(1));
    assign top_code = op_stack_reg[top_idx];
    assign cur_op   = op_code(byte_reg);
    assign out_free = !out_valid_reg || out_ready;

    assign stat.emit_ok    = last_reg ? (!hold_valid_reg || out_free) : out_free;
    assign stat.out_free   = out_free;
    assign stat.cls        = char_class(byte_reg);
    assign stat.op         = cur_op;
    assign stat.last       = last_reg;
    assign stat.discarding = discard_reg;
    assign stat.tok_open   = inside_reg;
    assign stat.prev       = prev_reg;
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.full       = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign stat.top_paren  = (top_code == OP_PAREN);
    assign stat.top_ge     = (op_prec(top_code) >= op_prec(cur_op));

    // Latch the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    // Operator stack storage, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            op_stack_reg[cnt_reg[IDX_W-1:0]] <= cmd.push_paren ? OP_PAREN : cur_op;
    end

    always_comb
    begin
        case (cmd.emit_src)
            SRC_CHAR:  new_res.data = byte_reg;
            SRC_SPACE: new_res.data = CH_SPACE;
            SRC_TOP:   new_res.data = op_char(top_code);
            SRC_ZERO:  new_res.data = CH_NUL;
            default:   new_res.data = CH_NUL;
        endcase
        new_res.last = cmd.emit_last;
        new_res.err  = cmd.emit_err;
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        inside_next     = inside_reg;
        prev_next       = prev_reg;
        discard_next    = discard_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cmd.push)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (cmd.pop)
            cnt_next = cnt_reg - CNT_W'(1);
        if (cmd.set_inside)
            inside_next = 1'b1;
        if (cmd.clr_inside)
            inside_next = 1'b0;
        if (cmd.set_prev)
            prev_next = cmd.prev_val;
        if (cmd.clear_expr)
        begin
            cnt_next    = '0;
            inside_next = 1'b0;
            prev_next   = PREV_START;
        end
        if (cmd.set_discard)
            discard_next = 1'b1;
        if (cmd.clr_discard)
            discard_next = 1'b0;

        // Results of a final item pass through the hold stage so that the
        // closing mark can be set on whichever result turns out to be last
        if (cmd.emit && !last_reg)
        begin
            out_next       = new_res;
            out_valid_next = 1'b1;
        end
        else if (cmd.emit)
        begin
            if (hold_valid_reg)
            begin
                out_next       = hold_reg;
                out_valid_next = 1'b1;
            end
            hold_next       = new_res;
            hold_valid_next = 1'b1;
        end
        else if (cmd.flush)
        begin
            if (hold_valid_reg)
            begin
                out_next      = hold_reg;
                out_next.last = 1'b1;
            end
            else
            begin
                out_next.data = CH_NUL;
                out_next.last = 1'b1;
                out_next.err  = ERR_NONE;
            end
            out_valid_next  = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            inside_reg     <= 1'b0;
            prev_reg       <= PREV_START;
            discard_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            inside_reg     <= inside_next;
            prev_reg       <= prev_next;
            discard_reg    <= discard_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_reg.data;
    assign out_last  = out_reg.last;
    assign out_error = out_reg.err;

    `I2P_ASSERT(a_cnt_range, 1'b1, cnt_reg <= CNT_W'(STACK_DEPTH))
    `I2P_ASSERT(a_push_room, cmd.push, cnt_reg != CNT_W'(STACK_DEPTH))
    `I2P_ASSERT(a_pop_nonempty, cmd.pop, cnt_reg != '0)
    `I2P_ASSERT(a_emit_slot, cmd.emit || cmd.flush, out_free || (last_reg && !hold_valid_reg))
    `I2P_ASSERT(a_hold_final, hold_valid_reg, last_reg)
    `I2P_ASSERT_NEXT(a_flush_empties, cmd.flush, !hold_valid_reg && out_valid_reg)

endmodule

`default_nettype wire

// ===== src/i2p_ctrl.sv =====
// Sequencer of the infix-to-postfix converter: decides per item which results
// to emit and how the stack moves. Uses i2p_pkg; drives i2p_datapath commands.
`default_nettype none

module i2p_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  i2p_pkg::i2p_stat_t  stat,
    output i2p_pkg::i2p_cmd_t   cmd
);
    import i2p_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DISPATCH  = 4'd1;
    localparam logic [3:0] ST_BODY      = 4'd2;
    localparam logic [3:0] ST_POP_SP    = 4'd3;
    localparam logic [3:0] ST_FIN_CLOSE = 4'd4;
    localparam logic [3:0] ST_FIN_POP   = 4'd5;
    localparam logic [3:0] ST_FIN_SP    = 4'd6;
    localparam logic [3:0] ST_ERR       = 4'd7;
    localparam logic [3:0] ST_FLUSH     = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] err_reg, err_next;
    logic [3:0] end_state;

    assign end_state = stat.last ? ST_FIN_CLOSE : ST_IDLE;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        err_next   = err_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                if (stat.discarding)
                begin
                    if (stat.last)
                    begin
                        cmd.clr_discard = 1'b1;
                        cmd.clear_expr  = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    case (stat.cls)
                        CLS_ALNUM:
                        begin
                            if (stat.emit_ok)
                            begin
                                cmd.emit       = 1'b1;
                                cmd.emit_src   = SRC_CHAR;
                                cmd.set_inside = 1'b1;
                                cmd.set_prev   = 1'b1;
                                cmd.prev_val   = PREV_OPND;
                                state_next     = end_state;
                            end
                        end
                        CLS_SPACE:
                        begin
                            if (!stat.tok_open)
                                state_next = end_state;
                            else if (stat.emit_ok)
                            begin
                                cmd.emit       = 1'b1;
                                cmd.emit_src   = SRC_SPACE;
                                cmd.clr_inside = 1'b1;
                                state_next     = end_state;
                            end
                        end
                        CLS_BAD:
                        begin
                            err_next   = ERR_BAD_CHAR;
                            state_next = ST_ERR;
                        end
                        default:
                        begin
                            // close an open token before any operator work
                            if (!stat.tok_open)
                                state_next = ST_BODY;
                            else if (stat.emit_ok)
                            begin
                                cmd.emit       = 1'b1;
                                cmd.emit_src   = SRC_SPACE;
                                cmd.clr_inside = 1'b1;
                                state_next     = ST_BODY;
                            end
                        end
                    endcase
                end
            end

            ST_BODY:
            begin
                case (stat.cls)
                    CLS_OPEN:
                    begin
                        if (stat.full)
                        begin
                            err_next   = ERR_OVERFLOW;
                            state_next = ST_ERR;
                        end
                        else
                        begin
                            cmd.push       = 1'b1;
                            cmd.push_paren = 1'b1;
                            cmd.set_prev   = 1'b1;
                            cmd.prev_val   = PREV_OPER;
                            state_next     = end_state;
                        end
                    end
                    CLS_CLOSE:
                    begin
                        if (stat.cnt_zero)
                        begin
                            err_next   = ERR_PAREN;
                            state_next = ST_ERR;
                        end
                        else if (stat.top_paren)
                        begin
                            cmd.pop      = 1'b1;
                            cmd.set_prev = 1'b1;
                            cmd.prev_val = PREV_CLOSE;
                            state_next   = end_state;
                        end
                        else if (stat.emit_ok)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_src = SRC_TOP;
                            cmd.pop      = 1'b1;
                            state_next   = ST_POP_SP;
                        end
                    end
                    CLS_OPER:
                    begin
                        if (stat.op == OP_SUB &&
                            (stat.prev == PREV_START || stat.prev == PREV_OPER))
                        begin
                            // sign: opens an operand token
                            if (stat.emit_ok)
                            begin
                                cmd.emit       = 1'b1;
                                cmd.emit_src   = SRC_CHAR;
                                cmd.set_inside = 1'b1;
                                cmd.set_prev   = 1'b1;
                                cmd.prev_val   = PREV_OPER;
                                state_next     = end_state;
                            end
                        end
                        else if (!stat.cnt_zero && !stat.top_paren && stat.top_ge)
                        begin
                            if (stat.emit_ok)
                            begin
                                cmd.emit     = 1'b1;
                                cmd.emit_src = SRC_TOP;
                                cmd.pop      = 1'b1;
                                state_next   = ST_POP_SP;
                            end
                        end
                        else if (stat.full)
                        begin
                            err_next   = ERR_OVERFLOW;
                            state_next = ST_ERR;
                        end
                        else
                        begin
                            cmd.push     = 1'b1;
                            cmd.set_prev = 1'b1;
                            cmd.prev_val = PREV_OPER;
                            state_next   = end_state;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_POP_SP:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = SRC_SPACE;
                    state_next   = ST_BODY;
                end
            end

            ST_FIN_CLOSE:
            begin
                if (!stat.tok_open)
                    state_next = ST_FIN_POP;
                else if (stat.emit_ok)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_src   = SRC_SPACE;
                    cmd.clr_inside = 1'b1;
                    state_next     = ST_FIN_POP;
                end
            end

            ST_FIN_POP:
            begin
                if (stat.cnt_zero)
                    state_next = ST_FLUSH;
                else if (stat.top_paren)
                begin
                    err_next   = ERR_PAREN;
                    state_next = ST_ERR;
                end
                else if (stat.emit_ok)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = SRC_TOP;
                    cmd.pop      = 1'b1;
                    state_next   = ST_FIN_SP;
                end
            end

            ST_FIN_SP:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = SRC_SPACE;
                    state_next   = ST_FIN_POP;
                end
            end

            ST_ERR:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_src    = SRC_ZERO;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_err    = err_reg;
                    cmd.clear_expr  = 1'b1;
                    cmd.set_discard = !stat.last;
                    state_next      = stat.last ? ST_FLUSH : ST_IDLE;
                end
            end

            ST_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.flush      = 1'b1;
                    cmd.clear_expr = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            err_reg   <= ERR_NONE;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for infix_to_postfix_converter: random and directed infix text,
// with a shunting-yard predictor checking every postfix byte that comes out.
// Depends on i2p_pkg (codes, characters, res_t) and the converter RTL.
`default_nettype none

module tb_top;
    import i2p_pkg::*;

    localparam int STACK_LIMIT = 16;
    localparam int ITEM_GOAL   = 180;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 80;

    // Shunting-yard predictor plus the queue of postfix bytes still owed by the DUT.
    class postfix_scoreboard;
        logic [2:0] op_stack [0:31];
        logic [4:0] depth_used;
        bit         in_token;
        logic [1:0] prev_kind;
        bit         dropping;
        res_t       due [$];
        res_t       step_out [$];
        int         mismatches;
        int         items_taken;
        int         bytes_checked;
        int         exprs_done;
        int         error_results;
        int         deepest;

        function new();
            foreach (op_stack[i]) op_stack[i] = OP_PAREN;
            depth_used = '0;
            in_token   = 1'b0;
            prev_kind  = PREV_START;
            dropping   = 1'b0;
        endfunction

        function logic [2:0] decode_oper(input logic [7:0] c);
            case (c)
                CH_PLUS:  return OP_ADD;
                CH_MINUS: return OP_SUB;
                CH_STAR:  return OP_MUL;
                CH_SLASH: return OP_DIV;
                CH_CARET: return OP_POW;
                default:  return OP_PAREN;
            endcase
        endfunction

        function logic [7:0] symbol_of(input logic [2:0] code);
            case (code)
                OP_ADD:  return CH_PLUS;
                OP_SUB:  return CH_MINUS;
                OP_MUL:  return CH_STAR;
                OP_DIV:  return CH_SLASH;
                OP_POW:  return CH_CARET;
                default: return CH_LPAREN;
            endcase
        endfunction

        function int rank_of(input logic [2:0] code);
            case (code)
                OP_ADD, OP_SUB: return 1;
                OP_MUL, OP_DIV: return 2;
                OP_POW:         return 3;
                default:        return 0;
            endcase
        endfunction

        function void put(input logic [7:0] b, input logic lst, input logic [1:0] e);
            res_t r;
            r.data = b;
            r.last = lst;
            r.err  = e;
            if (step_out.size() < 64)
                step_out.push_back(r);
        endfunction

        function void close_token();
            if (in_token) begin
                put(CH_SPACE, 1'b0, ERR_NONE);
                in_token = 1'b0;
            end
        endfunction

        function void pop_emit();
            depth_used--;
            put(symbol_of(op_stack[depth_used]), 1'b0, ERR_NONE);
            put(CH_SPACE, 1'b0, ERR_NONE);
        endfunction

        function void clear_expr();
            depth_used = '0;
            in_token   = 1'b0;
            prev_kind  = PREV_START;
        endfunction

        function logic [1:0] push_op(input logic [2:0] code);
            if (depth_used >= STACK_LIMIT)
                return ERR_OVERFLOW;
            op_stack[depth_used] = code;
            depth_used++;
            if (depth_used > deepest)
                deepest = depth_used;
            return ERR_NONE;
        endfunction

        // End mark: unwind the stack; a leftover '(' means an unclosed group.
        function logic [1:0] finish_expr();
            close_token();
            while (depth_used > 0) begin
                if (op_stack[depth_used - 1] == OP_PAREN)
                    return ERR_PAREN;
                pop_emit();
            end
            if (step_out.size() == 0)
                put(CH_NUL, 1'b1, ERR_NONE);
            else
                step_out[step_out.size() - 1].last = 1'b1;
            return ERR_NONE;
        endfunction

        // Note one accepted item; returns 0 when the item was dropped after an error.
        function bit note_input(input logic [7:0] c, input logic lst);
            logic [1:0] e;
            logic [2:0] code;
            logic [2:0] top;
            step_out.delete();
            e = ERR_NONE;
            if (dropping) begin
                if (lst) begin
                    dropping = 1'b0;
                    clear_expr();
                end
                return 1'b0;
            end
            items_taken++;
            code = decode_oper(c);
            if ((c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
                (c >= CH_LA && c <= CH_LZ)) begin
                put(c, 1'b0, ERR_NONE);
                in_token  = 1'b1;
                prev_kind = PREV_OPND;
            end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                close_token();
            end else if (c == CH_LPAREN) begin
                close_token();
                e = push_op(OP_PAREN);
                prev_kind = PREV_OPER;
            end else if (c == CH_RPAREN) begin
                close_token();
                while (depth_used > 0 && op_stack[depth_used - 1] != OP_PAREN)
                    pop_emit();
                if (depth_used == 0)
                    e = ERR_PAREN;
                else
                    depth_used--;
                prev_kind = PREV_CLOSE;
            end else if (code == OP_SUB &&
                         (prev_kind == PREV_START || prev_kind == PREV_OPER)) begin
                // sign: opens a token of its own
                close_token();
                put(CH_MINUS, 1'b0, ERR_NONE);
                in_token  = 1'b1;
                prev_kind = PREV_OPER;
            end else if (code != OP_PAREN) begin
                close_token();
                while (depth_used > 0) begin
                    top = op_stack[depth_used - 1];
                    if (top == OP_PAREN || rank_of(top) < rank_of(code))
                        break;
                    pop_emit();
                end
                e = push_op(code);
                prev_kind = PREV_OPER;
            end else begin
                e = ERR_BAD_CHAR;
            end

            if (e == ERR_NONE && lst)
                e = finish_expr();
            if (e != ERR_NONE) begin
                put(CH_NUL, 1'b1, e);
                clear_expr();
                dropping = !lst;
                error_results++;
            end else if (lst) begin
                clear_expr();
            end
            if (lst)
                exprs_done++;
            foreach (step_out[i]) due.push_back(step_out[i]);
            return 1'b1;
        endfunction

        function void check_result(input logic [7:0] b, input logic lst, input logic [1:0] e);
            res_t want;
            bytes_checked++;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: byte %02h last %0b err %0d",
                             $realtime, b, lst, e);
                return;
            end
            want = due.pop_front();
            if (b !== want.data || lst !== want.last || e !== want.err) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result %0d: want %02h/%0b/%0d, got %02h/%0b/%0d",
                             $realtime, bytes_checked, want.data, want.last, want.err,
                             b, lst, e);
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] out_error;

    postfix_scoreboard sb;

    // Characters of the expression about to be sent; the final one carries in_last.
    logic [7:0] expr_chars [$];
    int         burst_left = 1;
    bit         quiet_seq;

    // Receiver stall pattern state
    int         stall_mode = 0;
    int         mode_left  = 0;
    int         run_left   = 0;
    bit         ready_state;

    infix_to_postfix_converter #(.STACK_DEPTH(STACK_LIMIT)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_error (out_error)
    );

    always #6 clk = ~clk;

    // Watch both channels on the edge; values seen here are the pre-edge ones,
    // so the result never depends on event order within the step.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                void'(sb.note_input(in_byte, in_last));
            if (out_valid && out_ready)
                sb.check_result(out_byte, out_last, out_error);
        end
    end

    // Receiver: switch between always-ready, scattered stalls and long stall runs.
    always @(posedge clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 120);
        end
        mode_left--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (run_left == 0) begin
                    ready_state = !ready_state;
                    run_left    = $urandom_range(1, 8);
                end
                run_left--;
                out_ready <= ready_state;
            end
        endcase
    end

    // Hard stop in case the DUT hangs.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results still owed", CYCLE_LIMIT, sb.pending());
        $display("tb_top: done, errors");
        $finish;
    end

    function logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10)
            return CH_0 + 8'(r);
        else if (r < 36)
            return CH_UA + 8'(r - 10);
        else
            return CH_LA + 8'(r - 36);
    endfunction

    function logic [7:0] rand_oper();
        case ($urandom_range(0, 4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            default: return CH_CARET;
        endcase
    endfunction

    function logic [7:0] rand_blank();
        if ($urandom_range(0, 1) == 0)
            return CH_SPACE;
        return 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    function void load_text(input string s);
        expr_chars.delete();
        for (int i = 0; i < s.len(); i++)
            expr_chars.push_back(s[i]);
    endfunction

    // Well-formed infix text: optional groups and signs, multi-character operands,
    // scattered whitespace, every group closed before the end.
    function void make_wellformed(input int max_terms);
        int terms;
        int opens;
        terms = $urandom_range(1, max_terms);
        opens = 0;
        expr_chars.delete();
        for (int j = 0; j < terms; j++) begin
            while (opens < 5 && $urandom_range(0, 3) == 0) begin
                expr_chars.push_back(CH_LPAREN);
                opens++;
            end
            if ($urandom_range(0, 5) == 0)
                expr_chars.push_back(CH_MINUS);
            repeat ($urandom_range(1, 3)) expr_chars.push_back(rand_alnum());
            if ($urandom_range(0, 5) == 0)
                expr_chars.push_back(rand_blank());
            while (opens > 0 && $urandom_range(0, 2) == 0) begin
                expr_chars.push_back(CH_RPAREN);
                opens--;
            end
            if (j < terms - 1) begin
                expr_chars.push_back(rand_oper());
                if ($urandom_range(0, 5) == 0)
                    expr_chars.push_back(rand_blank());
            end
        end
        while (opens > 0) begin
            expr_chars.push_back(CH_RPAREN);
            opens--;
        end
    endfunction

    // Deep nesting around the stack limit; levels push either '(' alone or
    // an operator and a '(' so the overflow hits both kinds of push.
    function void make_deep(input int levels);
        expr_chars.delete();
        for (int j = 0; j < levels; j++) begin
            if ($urandom_range(0, 2) == 0) begin
                expr_chars.push_back(rand_alnum());
                expr_chars.push_back(rand_oper());
            end
            expr_chars.push_back(CH_LPAREN);
        end
        expr_chars.push_back(rand_alnum());
        repeat (levels) expr_chars.push_back(CH_RPAREN);
    endfunction

    function void make_noise();
        expr_chars.delete();
        repeat ($urandom_range(1, 6)) expr_chars.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Well-formed text with one character spoiled or a stray ')' inserted.
    function void make_broken();
        int pos;
        make_wellformed(5);
        pos = $urandom_range(0, expr_chars.size() - 1);
        case ($urandom_range(0, 3))
            0:       expr_chars[pos] = CH_RPAREN;
            1:       expr_chars[pos] = CH_LPAREN;
            2:       expr_chars.insert(pos, CH_RPAREN);
            default: expr_chars[pos] = 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Whitespace only, or a lone sign, possibly padded.
    function void make_blank();
        expr_chars.delete();
        if ($urandom_range(0, 1) == 0)
            expr_chars.push_back(CH_MINUS);
        repeat ($urandom_range(0, 3)) expr_chars.push_back(rand_blank());
        if (expr_chars.size() == 0)
            expr_chars.push_back(rand_blank());
    endfunction

    // Send one item and wait for its handshake. Between bursts drop valid for a
    // random gap; quiet sequences keep valid up back to back.
    task automatic send_char(input logic [7:0] c, input logic lst);
        in_valid <= 1'b1;
        in_byte  <= c;
        in_last  <= lst;
        do @(posedge clk); while (!in_ready);
        if (!quiet_seq) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 12);
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task automatic send_expr();
        for (int i = 0; i < expr_chars.size(); i++)
            send_char(expr_chars[i], i == expr_chars.size() - 1);
    endtask

    initial
    begin
        int  kind;
        bit  first_pass;
        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_byte   = 8'h00;
        in_last   = 1'b0;
        out_ready = 1'b0;
        quiet_seq = 1'b0;
        first_pass = 1'b1;

        // Hold reset, then release it on a rising edge.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: signed operand, all operators, grouping and whitespace.
        load_text("-a*(b + c)/d^e");
        send_expr();
        // Close with no open group.
        load_text(")");
        send_expr();
        // Group left open at the end mark.
        load_text("(");
        send_expr();
        // Bad character mid-expression, then drop up to the end mark.
        expr_chars.delete();
        expr_chars.push_back(8'h00);
        expr_chars.push_back(8'hFF);
        send_expr();
        // Bad character carrying the end mark itself.
        expr_chars.delete();
        expr_chars.push_back(8'h80);
        send_expr();
        // Expression with no postfix text; only a NUL result carrying the last flag comes out.
        expr_chars.delete();
        expr_chars.push_back(CH_TAB);
        send_expr();

        // Random: mostly well-formed text, some deep nesting, noise and spoiled text.
        // Open with a nest one past the stack limit so overflow is hit early.
        while (sb.items_taken < ITEM_GOAL) begin
            quiet_seq = ($urandom_range(0, 3) == 0);
            kind = first_pass ? 6 : $urandom_range(0, 9);
            if (kind <= 5)
                make_wellformed(8);
            else if (kind == 6)
                make_deep(first_pass ? STACK_LIMIT + 1 : $urandom_range(6, STACK_LIMIT + 2));
            else if (kind == 7)
                make_noise();
            else if (kind == 8)
                make_broken();
            else
                make_blank();
            first_pass = 1'b0;
            send_expr();
        end
        in_valid <= 1'b0;

        // Drain: wait for every owed byte, then a margin for strays.
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d characters in %0d expressions, %0d postfix bytes checked",
                 sb.items_taken, sb.exprs_done, sb.bytes_checked);
        $display("error results %0d, deepest operator stack %0d, mismatches %0d",
                 sb.error_results, sb.deepest, sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
